[rtl/rth_pkg.sv]
// Shared types and constants for the rectangle table hit test block.
`default_nettype none

package rth_pkg;

    localparam int MAX_RECTS  = 16;
    localparam int COORD_BITS = 12;
    localparam int IDX_W      = $clog2(MAX_RECTS);
    localparam int CNT_W      = $clog2(MAX_RECTS + 1);

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord width;
        t_coord height;
    } t_rect;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_MOVE   = 2'd1,
        OP_DELETE = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic               found;
        logic [IDX_W-1:0]   hit;
        logic [CNT_W-1:0]   count;
    } t_result;

    typedef struct packed {
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        t_rect              wr_data;
        logic [IDX_W-1:0]   rd_addr;
    } t_mem_req;

endpackage

`default_nettype wire

[rtl/rth_rect_mem.sv]
// Rectangle store: one write port, one read port with registered read data.
`default_nettype none

module rth_rect_mem (
    input  wire logic            i_clk,
    input  wire rth_pkg::t_mem_req i_req,
    output rth_pkg::t_rect       o_rd_data
);

    rth_pkg::t_rect r_mem [rth_pkg::MAX_RECTS];
    rth_pkg::t_rect r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/rth_hit_cmp.sv]
// Half-open containment test of one point against one rectangle.
`default_nettype none

module rth_hit_cmp (
    input  wire rth_pkg::t_rect  i_rect,
    input  wire rth_pkg::t_coord i_px,
    input  wire rth_pkg::t_coord i_py,
    output logic                 o_hit
);

    logic [rth_pkg::COORD_BITS:0] right_edge;
    logic [rth_pkg::COORD_BITS:0] bottom_edge;
    logic                         in_x;
    logic                         in_y;

    // Edges are one bit wider so a rectangle may reach past the coordinate range.
    assign right_edge  = {1'b0, i_rect.left} + {1'b0, i_rect.width};
    assign bottom_edge = {1'b0, i_rect.top}  + {1'b0, i_rect.height};
    assign in_x = (i_px >= i_rect.left) && ({1'b0, i_px} < right_edge);
    assign in_y = (i_py >= i_rect.top)  && ({1'b0, i_py} < bottom_edge);
    assign o_hit = in_x && in_y;

endmodule

`default_nettype wire

[rtl/rth_seq.sv]
// Operation sequencer: read-modify-write, shift and scan passes over the rectangle store.
`default_nettype none

module rth_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_op,
    input  wire logic [rth_pkg::IDX_W-1:0]     i_entry_index,
    input  wire rth_pkg::t_coord               i_pos_x,
    input  wire rth_pkg::t_coord               i_pos_y,
    input  wire rth_pkg::t_coord               i_size_w,
    input  wire rth_pkg::t_coord               i_size_h,
    output rth_pkg::t_mem_req                  o_mem_req,
    input  wire rth_pkg::t_rect                i_rd_data,
    output logic                               o_res_valid,
    output rth_pkg::t_result                   o_res,
    input  wire logic                          i_res_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOVE_WR,
        S_SHIFT,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                        r_state,  n_state;
    rth_pkg::t_op                  r_op,     n_op;
    logic [rth_pkg::IDX_W-1:0]     r_idx,    n_idx;
    rth_pkg::t_coord               r_px,     n_px;
    rth_pkg::t_coord               r_py,     n_py;
    rth_pkg::t_coord               r_sw,     n_sw;
    rth_pkg::t_coord               r_sh,     n_sh;
    logic [rth_pkg::CNT_W-1:0]     r_count,  n_count;
    logic [rth_pkg::IDX_W-1:0]     r_ptr,    n_ptr;
    rth_pkg::t_status              r_status, n_status;
    logic                          r_found,  n_found;
    logic [rth_pkg::IDX_W-1:0]     r_hit,    n_hit;

    logic [rth_pkg::CNT_W-1:0]     idx_ext;
    logic [rth_pkg::CNT_W-1:0]     ptr_ext;
    logic                          cmp_hit;

    rth_hit_cmp u_hit_cmp (
        .i_rect (i_rd_data),
        .i_px   (r_px),
        .i_py   (r_py),
        .o_hit  (cmp_hit)
    );

    assign idx_ext = {1'b0, r_idx};
    assign ptr_ext = {1'b0, r_ptr} + rth_pkg::CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_idx    = r_idx;
        n_px     = r_px;
        n_py     = r_py;
        n_sw     = r_sw;
        n_sh     = r_sh;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_status = r_status;
        n_found  = r_found;
        n_hit    = r_hit;

        o_mem_req.wr_en   = 1'b0;
        o_mem_req.wr_addr = r_idx;
        o_mem_req.wr_data = '{left: r_px, top: r_py, width: r_sw, height: r_sh};
        o_mem_req.rd_addr = r_ptr;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = rth_pkg::t_op'(i_op);
                    n_idx   = i_entry_index;
                    n_px    = i_pos_x;
                    n_py    = i_pos_y;
                    n_sw    = i_size_w;
                    n_sh    = i_size_h;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = rth_pkg::ST_OK;
                n_found  = 1'b0;
                n_hit    = '0;
                n_state  = S_DONE;
                case (r_op)
                    rth_pkg::OP_APPEND: begin
                        if (r_count == rth_pkg::CNT_W'(rth_pkg::MAX_RECTS)) begin
                            n_status = rth_pkg::ST_FULL;
                        end else begin
                            o_mem_req.wr_en   = 1'b1;
                            o_mem_req.wr_addr = r_count[rth_pkg::IDX_W-1:0];
                            n_count           = r_count + rth_pkg::CNT_W'(1);
                        end
                    end
                    rth_pkg::OP_MOVE: begin
                        if (idx_ext >= r_count) begin
                            n_status = rth_pkg::ST_BAD_INDEX;
                        end else begin
                            o_mem_req.rd_addr = r_idx;
                            n_state           = S_MOVE_WR;
                        end
                    end
                    rth_pkg::OP_DELETE: begin
                        if (idx_ext >= r_count) begin
                            n_status = rth_pkg::ST_BAD_INDEX;
                        end else if (idx_ext + rth_pkg::CNT_W'(1) < r_count) begin
                            o_mem_req.rd_addr = r_idx + rth_pkg::IDX_W'(1);
                            n_ptr             = r_idx + rth_pkg::IDX_W'(1);
                            n_state           = S_SHIFT;
                        end else begin
                            n_count = r_count - rth_pkg::CNT_W'(1);
                        end
                    end
                    rth_pkg::OP_QUERY: begin
                        if (r_count != '0) begin
                            o_mem_req.rd_addr = '0;
                            n_ptr             = '0;
                            n_state           = S_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            S_MOVE_WR: begin
                // Keep width and height from the entry just read.
                o_mem_req.wr_en   = 1'b1;
                o_mem_req.wr_addr = r_idx;
                o_mem_req.wr_data = '{left: r_px, top: r_py,
                                      width: i_rd_data.width, height: i_rd_data.height};
                n_state           = S_DONE;
            end
            S_SHIFT: begin
                // Read data holds entry r_ptr; drop it one place down.
                o_mem_req.wr_en   = 1'b1;
                o_mem_req.wr_addr = r_ptr - rth_pkg::IDX_W'(1);
                o_mem_req.wr_data = i_rd_data;
                if (ptr_ext < r_count) begin
                    o_mem_req.rd_addr = ptr_ext[rth_pkg::IDX_W-1:0];
                    n_ptr             = ptr_ext[rth_pkg::IDX_W-1:0];
                end else begin
                    n_count = r_count - rth_pkg::CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (cmp_hit) begin
                    n_found = 1'b1;
                    n_hit   = r_ptr;
                    n_state = S_DONE;
                end else if (ptr_ext < r_count) begin
                    o_mem_req.rd_addr = ptr_ext[rth_pkg::IDX_W-1:0];
                    n_ptr             = ptr_ext[rth_pkg::IDX_W-1:0];
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_px     <= n_px;
        r_py     <= n_py;
        r_sw     <= n_sw;
        r_sh     <= n_sh;
        r_ptr    <= n_ptr;
        r_status <= n_status;
        r_found  <= n_found;
        r_hit    <= n_hit;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{status: r_status, found: r_found, hit: r_hit, count: r_count};

endmodule

`default_nettype wire

[rtl/rectangle_table_hit_test.sv]
// Top level of the rectangle table hit test: sequencer, rectangle store and result register.
// Append, a bad index, deleting the last entry and a query of an empty table finish in decode;
// move reads the entry and writes it back; delete shifts each later entry one place down;
// query scans from entry 0 until the first hit or the last entry. The sequencer holds one item
// at a time and takes the next in the cycle after its result leaves the sequencer.
// Reset (synchronous, active low) empties the table and clears both valids; stale entries stay.
`default_nettype none

module rectangle_table_hit_test (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Item channel in
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [1:0]                 i_op,
    input  wire logic [rth_pkg::IDX_W-1:0]  i_entry_index,
    input  wire rth_pkg::t_coord            i_pos_x,
    input  wire rth_pkg::t_coord            i_pos_y,
    input  wire rth_pkg::t_coord            i_size_w,
    input  wire rth_pkg::t_coord            i_size_h,
    // Result channel out
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [1:0]                      o_status,
    output logic                            o_hit_found,
    output logic [rth_pkg::IDX_W-1:0]       o_hit_index,
    output logic [rth_pkg::CNT_W-1:0]       o_entry_count
);

    rth_pkg::t_mem_req mem_req;
    rth_pkg::t_rect    rd_data;
    rth_pkg::t_result  seq_res;
    logic              seq_res_valid;
    logic              res_ready;

    logic              r_out_valid;
    rth_pkg::t_result  r_out;

    // Sequencer: takes one item, walks the store, then holds its result until the
    // output register can take it.
    rth_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_size_w      (i_size_w),
        .i_size_h      (i_size_h),
        .o_mem_req     (mem_req),
        .i_rd_data     (rd_data),
        .o_res_valid   (seq_res_valid),
        .o_res         (seq_res),
        .i_res_ready   (res_ready)
    );

    // Single-port-write, single-port-read store; the sequencer never uses read data for an entry
    // read in the cycle it is written, so no forwarding is needed.
    rth_rect_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // Output register: load when empty or being drained, so the sequencer can take
    // the next item while a finished result still waits downstream.
    assign res_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (seq_res_valid && res_ready) begin
            r_out <= seq_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_hit_found   = r_out.found;
    assign o_hit_index   = r_out.hit;
    assign o_entry_count = r_out.count;

    // Count never exceeds the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= rth_pkg::CNT_W'(rth_pkg::MAX_RECTS)))
        else $error("entry count beyond table depth");

    // A hit always names a live entry.
    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_found) |-> ({1'b0, o_hit_index} < o_entry_count))
        else $error("hit index at or beyond entry count");

    // Only a successful query reports a hit.
    a_hit_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != rth_pkg::ST_OK)) |-> !o_hit_found)
        else $error("hit reported with error status");

    // The sequencer goes busy right after taking an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("sequencer not busy after accept");

endmodule

`default_nettype wire
